// ----- hw/rtl/trds_pkg.sv -----
package trds_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int OP_W        = 2;
    localparam int SIZE_W      = 25;
    localparam int BLK_W       = 16;
    localparam int LEN_W       = 10;
    localparam int ACT_W       = 3;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // largest file that fits in 65535 blocks
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(65535 * BLOCK_BYTES - 1);
    localparam logic [LEN_W-1:0]  FULL_LEN   = LEN_W'(BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] BLOCK_SZ   = SIZE_W'(BLOCK_BYTES);

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_WAIT   = 3'd0,
        ACT_SEND   = 3'd1,
        ACT_RESEND = 3'd2,
        ACT_DONE   = 3'd3,
        ACT_FAIL   = 3'd4,
        ACT_IDLE   = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        K_START,
        K_START_BAD,
        K_ACK,
        K_TICK,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'b01,
        PH_ACTIVE = 2'b10
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [SIZE_W-1:0] file_size;
        logic [BLK_W-1:0]  ack_block;
    } t_cmd;

endpackage

// ----- hw/rtl/trds_front.sv -----
module trds_front
    import trds_pkg::*;
(
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SIZE_W-1:0] i_file_size,
    input  logic [BLK_W-1:0]  i_ack_block,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_q_full
);

    t_kind w_kind;

    always_comb begin
        case (i_opcode)
            OP_START: w_kind = (i_file_size > SIZE_LIMIT) ? K_START_BAD : K_START;
            OP_ACK:   w_kind = K_ACK;
            OP_TICK:  w_kind = K_TICK;
            default:  w_kind = K_NOP;
        endcase
    end

    assign o_in_ready      = !i_q_full;
    assign o_push          = i_in_valid && !i_q_full;
    assign o_cmd.kind      = w_kind;
    assign o_cmd.file_size = i_file_size;
    assign o_cmd.ack_block = i_ack_block;

endmodule

// ----- hw/rtl/trds_queue.sv -----
module trds_queue
    import trds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

endmodule

// ----- hw/rtl/trds_back.sv -----
module trds_back
    import trds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_q_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ACT_W-1:0]     o_action,
    output logic [BLK_W-1:0]     o_block_number,
    output logic [LEN_W-1:0]     o_block_length,
    output logic [SIZE_W-1:0]    o_byte_offset
);

    logic [CFG_W-1:0]  r_max_retries;
    logic [CFG_W-1:0]  r_timeout;
    t_phase            r_phase, n_phase;
    logic [BLK_W-1:0]  r_cur, n_cur;
    logic [BLK_W-1:0]  r_acked, n_acked;
    logic [CFG_W-1:0]  r_retry, n_retry;
    logic [CFG_W-1:0]  r_secs, n_secs;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [SIZE_W-1:0] r_total, n_total;

    logic              r_out_valid;
    t_action           r_act, n_act;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic [LEN_W-1:0]  r_olen, n_olen;
    logic [SIZE_W-1:0] r_off, n_off;

    logic              w_start;
    logic [BLK_W-1:0]  w_base;
    logic [SIZE_W-1:0] w_tot;
    logic [BLK_W-1:0]  w_nb;
    logic [SIZE_W-1:0] w_end;
    logic [SIZE_W-1:0] w_rem;
    logic [LEN_W-1:0]  w_nlen;
    logic [CFG_W-1:0]  w_retry;
    logic [CFG_W-1:0]  w_secs;
    logic [BLK_W-1:0]  w_acked;
    logic              w_with_blk;

    assign o_pop = i_q_valid && (!r_out_valid || i_out_ready);

    // next-block length, shared by start and in-transfer sends
    assign w_start = (i_cmd.kind == K_START);
    assign w_base  = w_start ? '0 : r_cur;
    assign w_tot   = w_start ? i_cmd.file_size : r_total;
    assign w_nb    = w_base + 1'b1;
    assign w_end   = {w_nb, BLK_SHIFT'(0)};
    assign w_rem   = w_tot - (w_end - BLOCK_SZ);
    assign w_nlen  = (w_end > w_tot) ? w_rem[LEN_W-1:0] : FULL_LEN;

    always_comb begin
        n_phase    = r_phase;
        n_cur      = r_cur;
        n_acked    = r_acked;
        n_retry    = r_retry;
        n_secs     = r_secs;
        n_len      = r_len;
        n_total    = r_total;
        n_act      = ACT_WAIT;
        w_with_blk = 1'b0;
        w_retry    = r_retry;
        w_secs     = r_secs;
        w_acked    = r_acked;

        case (i_cmd.kind)
            K_START_BAD: begin
                n_phase = PH_IDLE;
                n_cur   = '0;
                n_acked = '0;
                n_retry = '0;
                n_secs  = '0;
                n_len   = '0;
                n_total = '0;
                n_act   = ACT_FAIL;
            end
            K_START: begin
                n_phase    = PH_ACTIVE;
                n_cur      = w_nb;
                n_acked    = '0;
                n_retry    = '0;
                n_secs     = '0;
                n_len      = w_nlen;
                n_total    = i_cmd.file_size;
                n_act      = ACT_SEND;
                w_with_blk = 1'b1;
            end
            default: begin
                if (r_phase != PH_ACTIVE) begin
                    n_act = ACT_IDLE;
                end else begin
                    if (i_cmd.kind == K_ACK) begin
                        w_retry = '0;
                        if (i_cmd.ack_block == r_cur) begin
                            w_acked = i_cmd.ack_block;
                        end
                    end else if (i_cmd.kind == K_TICK) begin
                        if (r_secs != '1) begin
                            w_secs = r_secs + 1'b1;
                        end
                    end
                    n_retry = w_retry;
                    n_secs  = w_secs;
                    n_acked = w_acked;

                    if (w_retry >= r_max_retries || (w_acked == r_cur && r_len < FULL_LEN))
                    begin
                        n_phase = PH_IDLE;
                        n_cur   = '0;
                        n_acked = '0;
                        n_retry = '0;
                        n_secs  = '0;
                        n_len   = '0;
                        n_total = '0;
                        n_act   = (w_retry >= r_max_retries) ? ACT_FAIL : ACT_DONE;
                    end else if (w_acked == r_cur) begin
                        n_cur      = w_nb;
                        n_retry    = '0;
                        n_secs     = '0;
                        n_len      = w_nlen;
                        n_act      = ACT_SEND;
                        w_with_blk = 1'b1;
                    end else if (w_secs >= r_timeout) begin
                        n_retry    = w_retry + 1'b1;
                        n_secs     = '0;
                        n_act      = ACT_RESEND;
                        w_with_blk = 1'b1;
                    end
                end
            end
        endcase

        if (w_with_blk) begin
            n_blk  = n_cur;
            n_olen = n_len;
            n_off  = (n_cur == '0) ? '0 : ({n_cur, BLK_SHIFT'(0)} - BLOCK_SZ);
        end else begin
            n_blk  = '0;
            n_olen = '0;
            n_off  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= CFG_W'(5);
            r_timeout     <= CFG_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data;
                CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cur       <= '0;
            r_acked     <= '0;
            r_retry     <= '0;
            r_secs      <= '0;
            r_len       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_cur   <= n_cur;
                r_acked <= n_acked;
                r_retry <= n_retry;
                r_secs  <= n_secs;
                r_len   <= n_len;
                r_total <= n_total;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act  <= n_act;
            r_blk  <= n_blk;
            r_olen <= n_olen;
            r_off  <= n_off;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_act;
    assign o_block_number = r_blk;
    assign o_block_length = r_olen;
    assign o_byte_offset  = r_off;

endmodule

// ----- hw/rtl/tftp_read_data_sender_top.sv -----
// Sending side of a lock-step TFTP read transfer.
// Input channel (i_in_valid / o_in_ready) carries one request per event:
// opcode 0 starts a transfer of i_file_size bytes, opcode 1 reports an
// acknowledgement for i_ack_block, opcode 2 is a one-second tick.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// request: the action (wait, send, resend, finished, failed, idle) and, for
// send and resend, the block number, its length and its byte offset.
// A request accepted at the input passes through the queue and then the output
// register before it is offered at the output.
// Throughput: one request per cycle while the receiver keeps taking results, set
// by the state update in the back end; the two-entry queue lets the front keep
// taking requests while a result waits at the output.
// Reset (synchronous, active low) returns the block to idle with all counters
// cleared, max_retries to 5 and timeout_seconds to 2.
// When the receiver stalls, the result holds, the back end stops, the queue
// fills and o_in_ready drops once both entries are taken.
// Config writes (i_cfg_we, index 0 max_retries, 1 timeout_seconds) take
// effect on the next edge and are expected only while the block is idle.
module tftp_read_data_sender_top
    import trds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [SIZE_W-1:0]    i_file_size,
    input  logic [BLK_W-1:0]     i_ack_block,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ACT_W-1:0]     o_action,
    output logic [BLK_W-1:0]     o_block_number,
    output logic [LEN_W-1:0]     o_block_length,
    output logic [SIZE_W-1:0]    o_byte_offset
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    // front: decode opcode, flag oversized starts
    trds_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_file_size (i_file_size),
        .i_ack_block (i_ack_block),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .i_q_full    (w_full)
    );

    // decoupling queue between classification and execution
    trds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    // back: transfer state, decision and registered result
    trds_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (w_q_valid),
        .i_cmd          (w_cmd_out),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_block_number (o_block_number),
        .o_block_length (o_block_length),
        .o_byte_offset  (o_byte_offset)
    );

endmodule

// ----- tb/tftp_read_data_sender_top_tb.sv -----
`timescale 1ns / 100ps

module tftp_read_data_sender_top_tb;
    import trds_pkg::*;

    // opcode 3 carries no event; the block just re-decides
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        t_action           act;
        logic [BLK_W-1:0]  blk;
        logic [LEN_W-1:0]  len;
        logic [SIZE_W-1:0] off;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  ack;
        bit                typed;
        t_action           act;
        logic [BLK_W-1:0]  blk;
        logic [LEN_W-1:0]  len;
        logic [SIZE_W-1:0] off;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_opcode = '0;
    logic [SIZE_W-1:0]    i_file_size = '0;
    logic [BLK_W-1:0]     i_ack_block = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ACT_W-1:0]     o_action;
    logic [BLK_W-1:0]     o_block_number;
    logic [LEN_W-1:0]     o_block_length;
    logic [SIZE_W-1:0]    o_byte_offset;

    tftp_read_data_sender_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_file_size    (i_file_size),
        .i_ack_block    (i_ack_block),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_block_number (o_block_number),
        .o_block_length (o_block_length),
        .o_byte_offset  (o_byte_offset)
    );

    // ---------------------------------------------------------------
    // Transfer state mirror, updated at each accepted request
    // ---------------------------------------------------------------
    bit                xfer_active;
    logic [BLK_W-1:0]  cur_blk;
    logic [BLK_W-1:0]  acked_blk;
    logic [7:0]        retry_cnt;
    logic [7:0]        secs_idle;
    logic [LEN_W-1:0]  blk_len;
    logic [SIZE_W-1:0] file_bytes;
    logic [CFG_W-1:0]  retry_budget;
    logic [CFG_W-1:0]  timeout_secs;

    result_t due_actions[$];   // actions owed by the block, oldest first
    t_action last_act;         // action predicted for the latest request
    int      errors;

    // idle/stall knobs, percent of cycles
    int gap_pct;
    int stall_pct;
    // long receiver hold-off: main bumps the request count, receiver counts cycles
    int hold_reqs;
    int hold_seen;
    int hold_left;

    function automatic void clear_transfer();
        xfer_active = 1'b0;
        cur_blk     = '0;
        acked_blk   = '0;
        retry_cnt   = '0;
        secs_idle   = '0;
        blk_len     = '0;
        file_bytes  = '0;
    endfunction

    function automatic result_t make_result(t_action a, bit with_blk);
        result_t r;
        r     = '0;
        r.act = a;
        if (with_blk) begin
            r.blk = cur_blk;
            r.len = blk_len;
            if (cur_blk != 0)
                r.off = SIZE_W'((int'(cur_blk) - 1) * BLOCK_BYTES);
        end
        return r;
    endfunction

    function automatic result_t next_block();
        int last_byte;
        cur_blk   = cur_blk + 1'b1;
        retry_cnt = '0;
        secs_idle = '0;
        last_byte = int'(cur_blk) * BLOCK_BYTES;
        // short tail block once the file end falls inside this block
        if (last_byte > int'(file_bytes))
            blk_len = LEN_W'(int'(file_bytes) - (last_byte - BLOCK_BYTES));
        else
            blk_len = LEN_W'(BLOCK_BYTES);
        return make_result(ACT_SEND, 1'b1);
    endfunction

    function automatic result_t decide_action();
        if (retry_cnt >= retry_budget) begin
            clear_transfer();
            return make_result(ACT_FAIL, 1'b0);
        end
        if (acked_blk == cur_blk && int'(blk_len) < BLOCK_BYTES) begin
            clear_transfer();
            return make_result(ACT_DONE, 1'b0);
        end
        if (acked_blk == cur_blk)
            return next_block();
        if (secs_idle >= timeout_secs) begin
            retry_cnt = retry_cnt + 1'b1;
            secs_idle = '0;
            return make_result(ACT_RESEND, 1'b1);
        end
        return make_result(ACT_WAIT, 1'b0);
    endfunction

    function automatic result_t predict_action(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                               logic [BLK_W-1:0] ack);
        if (op == OP_START) begin
            clear_transfer();
            if (size > SIZE_LIMIT)
                return make_result(ACT_FAIL, 1'b0);
            file_bytes  = size;
            xfer_active = 1'b1;
            return next_block();
        end
        if (!xfer_active)
            return make_result(ACT_IDLE, 1'b0);
        if (op == OP_ACK) begin
            // any ack clears retries, only a matching one counts
            retry_cnt = '0;
            if (ack == cur_blk)
                acked_blk = ack;
        end else if (op == OP_TICK) begin
            if (secs_idle != 8'hFF)
                secs_idle = secs_idle + 1'b1;
        end
        return decide_action();
    endfunction

    // ---------------------------------------------------------------
    // Clock, limit
    // ---------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tftp_read_data_sender_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver side: random/held ready, result check against due_actions
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        result_t exp_r;
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            i_out_ready <= 1'b0;
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_actions.size() == 0) begin
                errors++;
                $display("%0t: unexpected result action=%0d blk=%0d", $time,
                         o_action, o_block_number);
            end else begin
                exp_r = due_actions.pop_front();
                if (o_action !== exp_r.act) begin
                    errors++;
                    $display("%0t: action expected %0d actual %0d", $time,
                             exp_r.act, o_action);
                end
                if (o_block_number !== exp_r.blk) begin
                    errors++;
                    $display("%0t: block_number expected %0d actual %0d", $time,
                             exp_r.blk, o_block_number);
                end
                if (o_block_length !== exp_r.len) begin
                    errors++;
                    $display("%0t: block_length expected %0d actual %0d", $time,
                             exp_r.len, o_block_length);
                end
                if (o_byte_offset !== exp_r.off) begin
                    errors++;
                    $display("%0t: byte_offset expected %0d actual %0d", $time,
                             exp_r.off, o_byte_offset);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Offers one request and returns in the time step of its acceptance,
    // valid still high; the caller either offers the next one or releases.
    task automatic drive_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                                 input logic [BLK_W-1:0] ack, input bit typed,
                                 input result_t typed_r);
        result_t pred;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < gap_pct);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_file_size <= size;
        i_ack_block <= ack;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pred     = predict_action(op, size, ack);
        last_act = pred.act;
        due_actions.push_back(typed ? typed_r : pred);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (due_actions.size() != 0)
            @(posedge i_clk);
    endtask

    // both registers, back to back; only with nothing in flight
    task automatic write_config(input logic [CFG_W-1:0] retries, input logic [CFG_W-1:0] tmo);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_RETRIES;
        i_cfg_data <= retries;
        @(posedge i_clk);
        retry_budget = retries;
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        timeout_secs = tmo;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return SIZE_W'($urandom_range(0, 3 * BLOCK_BYTES + 50));
        if (r < 70)
            return SIZE_W'(BLOCK_BYTES * $urandom_range(0, 4));
        if (r < 80)
            return SIZE_W'($urandom);
        if (r < 90)
            return SIZE_W'(int'(SIZE_LIMIT) - 2 + $urandom_range(0, 4));
        return SIZE_W'($urandom_range(0, 40 * BLOCK_BYTES));
    endfunction

    // Mostly well-formed lock-step traffic against the mirrored block
    // number, with duplicate/stray acks, restarts and no-ops mixed in.
    task automatic run_random(input int quota, input int ack_pct, input bit with_hold,
                              input bit with_pause);
        int               counted;
        int               r;
        int               burst;
        bit               held;
        logic [OP_W-1:0]  op;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0] ack;
        counted = 0;
        held    = 1'b0;
        while (counted < quota) begin
            // hold starts once halfway, even if a tick run jumps past the mark
            if (with_hold && !held && counted >= quota / 2) begin
                held = 1'b1;
                hold_reqs <= hold_reqs + 1;
            end
            if (with_pause && counted == quota / 3) begin
                release_input();
                wait_drained();
            end
            op   = OP_START;
            size = SIZE_W'($urandom);
            ack  = BLK_W'($urandom);
            r    = $urandom_range(99);
            if (xfer_active) begin
                if (r < ack_pct) begin
                    op  = OP_ACK;
                    ack = cur_blk;
                end else if (r < 70) begin
                    op = OP_TICK;
                end else if (r < 73) begin
                    // run of ticks with no ack: drives resends into failure
                    burst = ($urandom_range(3) == 0) ? $urandom_range(1, 300)
                                                     : $urandom_range(1, 12);
                    repeat (burst) begin
                        if (with_hold && !held && counted >= quota / 2) begin
                            held = 1'b1;
                            hold_reqs <= hold_reqs + 1;
                        end
                        drive_request(OP_TICK, SIZE_W'($urandom), BLK_W'($urandom),
                                      1'b0, '0);
                        counted++;
                    end
                    continue;
                end else if (r < 85) begin
                    op = OP_ACK;
                    case ($urandom_range(2))
                        0: ack = acked_blk;
                        1: ack = cur_blk + 1'b1;
                        default: ;
                    endcase
                end else if (r < 90) begin
                    op = OP_NOP;
                end else if (r < 95) begin
                    size = pick_size();
                end else begin
                    op = OP_ACK;
                end
            end else if (r < 85) begin
                size = pick_size();
            end else begin
                op = OP_TICK + OP_W'($urandom_range(0, 1)) - OP_W'($urandom_range(0, 1));
                if (op == OP_START)
                    op = OP_NOP;
            end
            drive_request(op, size, ack, 1'b0, '0);
            if (last_act != ACT_IDLE)
                counted++;
        end
    endtask

    // Directed opening: idle events, size limits, tail blocks, resend, restart.
    dir_row_t dir_rows [25] = '{
        '{OP_ACK,   25'd0,        16'd0,     1'b1, ACT_IDLE, 16'd0, 10'd0,   25'd0},
        '{OP_TICK,  25'd0,        16'd0,     1'b1, ACT_IDLE, 16'd0, 10'd0,   25'd0},
        '{OP_NOP,   25'h1FFFFFF,  16'hFFFF,  1'b1, ACT_IDLE, 16'd0, 10'd0,   25'd0},
        // one past the largest file, then all ones: both refused
        '{OP_START, 25'd33553920, 16'd0,     1'b1, ACT_FAIL, 16'd0, 10'd0,   25'd0},
        '{OP_START, 25'h1FFFFFF,  16'd0,     1'b1, ACT_FAIL, 16'd0, 10'd0,   25'd0},
        // empty file: one zero-length block, finished on its ack
        '{OP_START, 25'd0,        16'd0,     1'b1, ACT_SEND, 16'd1, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd1,     1'b1, ACT_DONE, 16'd0, 10'd0,   25'd0},
        '{OP_START, 25'd33553919, 16'd0,     1'b1, ACT_SEND, 16'd1, 10'd512, 25'd0},
        '{OP_ACK,   25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_TICK,  25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_TICK,  25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_NOP,   25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'hFFFF,  1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd1,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        // restart in the middle of a transfer
        '{OP_START, 25'd1000,     16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd1,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd2,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        // exact multiple of a block: trailing zero-length block
        '{OP_START, 25'd512,      16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd1,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd2,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_START, 25'd100,      16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_TICK,  25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_TICK,  25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_ACK,   25'd0,        16'd0,     1'b0, ACT_WAIT, 16'd0, 10'd0,   25'd0},
        '{OP_START, 25'd33553920, 16'd0,     1'b1, ACT_FAIL, 16'd0, 10'd0,   25'd0}
    };

    // per-phase register settings; phase 0 keeps the reset values
    int phase_retries [NUM_PHASES] = '{5, 1, 255, 0, 0, 3, 255, 1, -1, -1};
    int phase_timeout [NUM_PHASES] = '{2, 1, 255, 0, 3, 0, 1, 255, -1, -1};

    initial begin
        result_t          typed_r;
        logic [CFG_W-1:0] new_retries;
        logic [CFG_W-1:0] new_timeout;
        errors       = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_reqs    = 0;
        hold_seen    = 0;
        hold_left    = 0;
        retry_budget = 8'd5;
        timeout_secs = 8'd2;
        clear_transfer();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            typed_r = '{dir_rows[i].act, dir_rows[i].blk, dir_rows[i].len, dir_rows[i].off};
            drive_request(dir_rows[i].op, dir_rows[i].size, dir_rows[i].ack,
                          dir_rows[i].typed, typed_r);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            // park the transfer (oversized start fails it) and drain first
            if (xfer_active)
                drive_request(OP_START, SIZE_W'(33553920), '0, 1'b0, '0);
            release_input();
            wait_drained();
            if (p > 0) begin
                new_retries = (phase_retries[p] < 0) ? CFG_W'($urandom_range(0, 8))
                                                     : CFG_W'(phase_retries[p]);
                new_timeout = (phase_timeout[p] < 0) ? CFG_W'($urandom_range(0, 255))
                                                     : CFG_W'(phase_timeout[p]);
                write_config(new_retries, new_timeout);
            end
            case (p % 4)
                0: begin gap_pct <= 0;  stall_pct <= 0;  end
                1: begin gap_pct <= 88; stall_pct <= 0;  end
                2: begin gap_pct <= 0;  stall_pct <= 88; end
                default: begin gap_pct <= 12; stall_pct <= 12; end
            endcase
            @(posedge i_clk);
            run_random(172, (p == 6) ? 25 : 55, p == 0, p == 4);
        end

        release_input();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && due_actions.size() == 0) begin
            $display("tftp_read_data_sender_top regression: pass");
        end else begin
            $display("tftp_read_data_sender_top regression: fail");
        end
        $finish;
    end

endmodule
